/* design/ierf_pkg.sv */
// ----------------------------------------------------------------------------
// ierf_pkg
// Shared types and constants for the inverse error function pipeline.
// ----------------------------------------------------------------------------
package ierf_pkg;

   localparam int ARG_W  = 32;
   localparam int TMAG_W = 37;
   localparam int LOG_STEPS = 32;
   localparam int HORNER_STEPS = 9;

   // ln(2) in Q.62
   localparam logic [61:0] LN2_Q62 = 62'h2C5C85FDF473DE6B;

   // branch threshold 6.125 in Q.32
   localparam logic [TMAG_W-1:0] TSPLIT_Q32 = TMAG_W'(49) << 29;

   // Horner sums saturate at +-2^62
   localparam logic [62:0] SAT62_MAG = 63'(1) << 62;

   localparam logic signed [63:0] COEF_TAIL [HORNER_STEPS] = '{
      64'sh14deb44,
      64'sh1f7c9ae << 6,
      64'sh147e512 << 12,
      64'sh1dca7de << 16,
      64'sh19cab92 << 20,
      64'sh18cc0de << 23,
      64'sh13ca920 << 24,
      -(64'sh10eff66 << 30),
      64'sh1ae16a4 << 31
   };

   localparam logic signed [63:0] COEF_CORE [HORNER_STEPS+1] = '{
      64'sh175c000 << 4,
      64'sh133b402 << 9,
      64'sh1499232 << 12,
      64'sh1e52cd2 << 8,
      -(64'sh1d70bd0 << 17),
      -(64'sh135be90 << 19),
      64'sh12f6400 << 23,
      64'sh17a1e50 << 25,
      -(64'sh1db2aee << 29),
      64'sh1c5bf88 << 31
   };

   // one classified item between front and back
   typedef struct packed {
      logic signed [ARG_W-1:0] arg;
      logic [TMAG_W-1:0]       tmag;   // t = -tmag, Q.32
      logic                    tail;   // use the nine-term polynomial
   } ierf_item_type;

endpackage

/* design/ierf_front.sv */
// ----------------------------------------------------------------------------
// ierf_front
// Accepts arguments, forms t = ln(1 - a*a) and picks the polynomial branch.
// ----------------------------------------------------------------------------
module ierf_front
   import ierf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic signed [ARG_W-1:0] in_arg,
   output logic                    out_valid,
   output ierf_item_type           out_item
);

   // input capture, -1 folded to -(1 - 2^-31)
   logic                    v0_ff;
   logic signed [ARG_W-1:0] a0_ff;
   // u = 2^62 - a*a
   logic                    v1_ff;
   logic signed [ARG_W-1:0] a1_ff;
   logic [62:0]             u1_ff;
   // leading one
   logic                    v2_ff;
   logic signed [ARG_W-1:0] a2_ff;
   logic [62:0]             u2_ff;
   logic [5:0]              k2_ff;
   // normalized mantissa
   logic                    v3_ff;
   logic signed [ARG_W-1:0] a3_ff;
   logic [5:0]              k3_ff;
   logic [30:0]             m3_ff;
   // squaring stages
   logic                    lv_ff [LOG_STEPS];
   logic signed [ARG_W-1:0] la_ff [LOG_STEPS];
   logic [5:0]              lk_ff [LOG_STEPS];
   logic [30:0]             lm_ff [LOG_STEPS];
   logic [31:0]             lf_ff [LOG_STEPS];
   // |log2| in Q.32
   logic                    v4_ff;
   logic signed [ARG_W-1:0] a4_ff;
   logic [TMAG_W-1:0]       ml4_ff;
   // partial products with ln2
   logic                    v5_ff;
   logic signed [ARG_W-1:0] a5_ff;
   logic [68:0]             plo5_ff;
   logic [66:0]             phi5_ff;
   // t and branch
   logic                    v6_ff;
   ierf_item_type           item6_ff;

   logic [30:0]  mag0;
   logic [5:0]   k_in;
   logic [99:0]  full5;
   logic [TMAG_W-1:0] tmag_in;

   assign mag0 = a0_ff[ARG_W-1] ? 31'(-a0_ff) : 31'(a0_ff);

   always_comb begin
      k_in = 6'd31;
      for (int i = 31; i <= 62; i++) begin
         if (u1_ff[i]) begin
            k_in = 6'(i);
         end
      end
   end

   assign full5 = {1'b0, phi5_ff, 32'b0} + 100'(plo5_ff) + (100'(1) << 61);
   assign tmag_in = full5[62+TMAG_W-1:62];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= lv_ff[LOG_STEPS-1];
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a0_ff <= (in_arg == {1'b1, {(ARG_W-1){1'b0}}}) ?
                  (in_arg + ARG_W'(1)) : in_arg;
         a1_ff <= a0_ff;
         u1_ff <= (63'(1) << 62) - 63'(62'(mag0) * 62'(mag0));
         a2_ff <= a1_ff;
         u2_ff <= u1_ff;
         k2_ff <= k_in;
         a3_ff <= a2_ff;
         k3_ff <= k2_ff;
         m3_ff <= 31'(u2_ff >> (k2_ff - 6'd30));
         a4_ff <= la_ff[LOG_STEPS-1];
         ml4_ff <= {5'(6'd62 - lk_ff[LOG_STEPS-1]), 32'b0}
                   - TMAG_W'(lf_ff[LOG_STEPS-1]);
         a5_ff <= a4_ff;
         plo5_ff <= 69'(ml4_ff) * 69'(LN2_Q62[31:0]);
         phi5_ff <= 67'(ml4_ff) * 67'(LN2_Q62[61:32]);
         item6_ff.arg  <= a5_ff;
         item6_ff.tmag <= tmag_in;
         item6_ff.tail <= tmag_in > TSPLIT_Q32;
      end
   end

   // one fraction bit of log2 per stage: square, renormalize
   for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
      logic [30:0]  m_prev;
      logic [31:0]  f_prev;
      logic [61:0]  sq;
      logic [31:0]  q;

      if (j == 0) begin : g_first
         assign m_prev = m3_ff;
         assign f_prev = 32'b0;
         always_ff @(posedge clock) begin
            if (reset) begin
               lv_ff[j] <= 1'b0;
            end else if (enable) begin
               lv_ff[j] <= v3_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               la_ff[j] <= a3_ff;
               lk_ff[j] <= k3_ff;
            end
         end
      end else begin : g_next
         assign m_prev = lm_ff[j-1];
         assign f_prev = lf_ff[j-1];
         always_ff @(posedge clock) begin
            if (reset) begin
               lv_ff[j] <= 1'b0;
            end else if (enable) begin
               lv_ff[j] <= lv_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               la_ff[j] <= la_ff[j-1];
               lk_ff[j] <= lk_ff[j-1];
            end
         end
      end

      assign sq = 62'(m_prev) * 62'(m_prev);
      assign q  = sq[61:30];

      always_ff @(posedge clock) begin
         if (enable) begin
            lm_ff[j] <= q[31] ? q[31:1] : q[30:0];
            lf_ff[j] <= {f_prev[30:0], q[31]};
         end
      end
   end

   assign out_valid = v6_ff;
   assign out_item  = item6_ff;

endmodule

/* design/ierf_queue.sv */
// ----------------------------------------------------------------------------
// ierf_queue
// Short FIFO between the classifying front and the polynomial back.
// ----------------------------------------------------------------------------
module ierf_queue
   import ierf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ierf_item_type push_item,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output ierf_item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ierf_item_type       store_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = store_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* design/ierf_back.sv */
// ----------------------------------------------------------------------------
// ierf_back
// Horner evaluation of the selected polynomial in t, then the product a*p.
// ----------------------------------------------------------------------------
module ierf_back
   import ierf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  ierf_item_type           in_item,
   output logic                    out_valid,
   output logic signed [ARG_W-1:0] out_value
);

   localparam int NS = HORNER_STEPS + 1;

   // Horner accumulator stages, index 0 is the entry stage
   logic                    hv_ff [NS];
   logic signed [63:0]      hp_ff [NS];
   ierf_item_type           hi_ff [NS];
   // multiply stages, one per Horner step
   logic                    mv_ff [1:NS-1];
   logic                    mneg_ff [1:NS-1];
   logic [68:0]             mlo_ff [1:NS-1];
   logic [67:0]             mhi_ff [1:NS-1];
   ierf_item_type           mi_ff [1:NS-1];
   // final product
   logic                    fv_ff;
   logic                    fneg_ff;
   logic [62:0]             flo_ff;
   logic [61:0]             fhi_ff;
   logic                    ov_ff;
   logic signed [ARG_W-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff[0] <= 1'b0;
      end else if (enable) begin
         hv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hp_ff[0] <= COEF_CORE[0];
         hi_ff[0] <= in_item;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_step
      logic [62:0]        pmag;
      logic [99:0]        full;
      logic [67:0]        scaled;
      logic [62:0]        mag;
      logic signed [63:0] prod;
      logic signed [63:0] coef;
      logic signed [64:0] sum;
      logic signed [63:0] sum_sat;

      assign pmag = hp_ff[s-1][63] ? 63'(-hp_ff[s-1]) : 63'(hp_ff[s-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            mv_ff[s] <= 1'b0;
            hv_ff[s] <= 1'b0;
         end else if (enable) begin
            mv_ff[s] <= hv_ff[s-1];
            hv_ff[s] <= mv_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            mneg_ff[s] <= hp_ff[s-1][63];
            mlo_ff[s]  <= 69'(pmag[31:0]) * 69'(hi_ff[s-1].tmag);
            mhi_ff[s]  <= 68'(pmag[62:32]) * 68'(hi_ff[s-1].tmag);
            mi_ff[s]   <= hi_ff[s-1];
         end
      end

      // t is never positive, so the product takes the opposite sign of p
      assign full   = {mhi_ff[s], 32'b0} + 100'(mlo_ff[s]) + (100'(1) << 31);
      assign scaled = full[99:32];
      assign mag    = (scaled > 68'(SAT62_MAG)) ? SAT62_MAG : scaled[62:0];
      assign prod   = mneg_ff[s] ? 64'(mag) : -64'(mag);
      assign coef   = mi_ff[s].tail ? COEF_TAIL[s-1] : COEF_CORE[s];
      assign sum    = 65'(prod) + 65'(coef);

      always_comb begin
         if (sum > $signed(65'(SAT62_MAG))) begin
            sum_sat = 64'(SAT62_MAG);
         end else if (sum < -$signed(65'(SAT62_MAG))) begin
            sum_sat = -64'(SAT62_MAG);
         end else begin
            sum_sat = 64'(sum);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            hi_ff[s] <= mi_ff[s];
            // the nine-term polynomial skips the first step
            if (s == 1 && mi_ff[s].tail) begin
               hp_ff[s] <= COEF_TAIL[0];
            end else begin
               hp_ff[s] <= sum_sat;
            end
         end
      end
   end

   logic [62:0] ppmag;
   logic [30:0] amag;
   logic [95:0] ffull;
   logic [36:0] fmag;

   assign ppmag = hp_ff[NS-1][63] ? 63'(-hp_ff[NS-1]) : 63'(hp_ff[NS-1]);
   assign amag  = hi_ff[NS-1].arg[ARG_W-1] ? 31'(-hi_ff[NS-1].arg)
                                           : 31'(hi_ff[NS-1].arg);
   assign ffull = {2'b0, fhi_ff, 32'b0} + 96'(flo_ff) + (96'(1) << 58);
   assign fmag  = ffull[95:59];

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (enable) begin
         fv_ff <= hv_ff[NS-1];
         ov_ff <= fv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fneg_ff <= hi_ff[NS-1].arg[ARG_W-1] ^ hp_ff[NS-1][63];
         flo_ff  <= 63'(ppmag[31:0]) * 63'(amag);
         fhi_ff  <= 62'(ppmag[62:32]) * 62'(amag);
         if (fneg_ff) begin
            out_ff <= (fmag > 37'(33'h080000000)) ? {1'b1, {(ARG_W-1){1'b0}}}
                                                  : ARG_W'(-fmag);
         end else begin
            out_ff <= (fmag > 37'(33'h07FFFFFFF)) ? {1'b0, {(ARG_W-1){1'b1}}}
                                                  : ARG_W'(fmag);
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_value = out_ff;

endmodule

/* design/inverse_error_function.sv */
// ----------------------------------------------------------------------------
// inverse_error_function
// Fixed-point erfinv: Q1.31 argument in, saturated Q4.28 result out.
// ----------------------------------------------------------------------------
// The block takes one argument per cycle while req_stall is low and returns
// one result per argument, in order. A transfer on either channel happens at
// a clock edge where valid is high and stall is low. The front end (39
// stages) forms 1 - a*a, normalizes it, extracts 32 bits of log2 by one
// squaring stage per bit and scales by ln2 to get t, then picks the nine- or
// ten-term polynomial. A four-entry queue decouples it from the back end (21
// stages): nine Horner steps of two stages each (split multiply, then round,
// saturate and add the coefficient) and a two-stage final product a*p.
// Sustained rate is one transfer per cycle when nothing stalls. Each half
// freezes as a whole when its downstream side is full; the queue absorbs the
// difference between them.
// ----------------------------------------------------------------------------
module inverse_error_function
   import ierf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [ARG_W-1:0] req_arg_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [ARG_W-1:0] rsp_inv_erf_value
);

   logic          front_en;
   logic          front_valid;
   ierf_item_type front_item;
   logic          q_full;
   logic          q_not_empty;
   ierf_item_type q_head;
   logic          q_push;
   logic          q_pop;
   logic          back_en;

   // hold the front while its last stage cannot move into the queue
   assign front_en  = !(front_valid && q_full);
   assign req_stall = !front_en;
   assign q_push    = front_valid && !q_full;

   // hold the back while the result register waits on the consumer
   assign back_en = !(rsp_valid && rsp_stall);
   assign q_pop   = q_not_empty && back_en;

   ierf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (front_en),
      .in_valid  (req_valid),
      .in_arg    (req_arg_value),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   ierf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (q_head)
   );

   ierf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (back_en),
      .in_valid  (q_not_empty),
      .in_item   (q_head),
      .out_valid (rsp_valid),
      .out_value (rsp_inv_erf_value)
   );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Inverse error function testbench
// Drives Q1.31 arguments through the erfinv pipeline under random idling on
// both sides and checks each Q4.28 result against a bit-exact predictor or table.
// ----------------------------------------------------------------------------
module testbench;
   import ierf_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 120;

   // ln(2) in Q.62 and the branch threshold, kept locally for the predictor
   localparam longint LN2_FIXED   = 64'h2C5C85FDF473DE6B;
   localparam longint TAIL_SPLIT  = 64'd49 << 29;
   localparam longint HORNER_LIM  = 64'd1 << 62;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ARG_W-1:0] req_arg_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ARG_W-1:0] rsp_inv_erf_value;

   inverse_error_function dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_arg_value(req_arg_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_inv_erf_value(rsp_inv_erf_value)
   );

   always #4 clock = ~clock;

   // expected results in arrival order
   logic signed [31:0] erfinv_queue[$];
   int  failures = 0;
   int  results_seen = 0;
   int  args_sent = 0;
   longint cycle_count = 0;
   int  send_idle_pct = 26;
   int  recv_idle_pct = 50;

   // coefficient tables in Q.56, written from the single-precision values
   longint tail_coef[9];
   longint core_coef[10];

   function automatic longint coef_q56(longint mant, int expo);
      return mant <<< (expo + 32);
   endfunction

   initial begin
      tail_coef = '{coef_q56(64'h14deb44, -32), coef_q56(64'h1f7c9ae, -26),
                    coef_q56(64'h147e512, -20), coef_q56(64'h1dca7de, -16),
                    coef_q56(64'h19cab92, -12), coef_q56(64'h18cc0de, -9),
                    coef_q56(64'h13ca920, -8), -coef_q56(64'h10eff66, -2),
                    coef_q56(64'h1ae16a4, -1)};
      core_coef = '{coef_q56(64'h175c000, -28), coef_q56(64'h133b402, -23),
                    coef_q56(64'h1499232, -20), coef_q56(64'h1e52cd2, -24),
                    -coef_q56(64'h1d70bd0, -15), -coef_q56(64'h135be90, -13),
                    coef_q56(64'h12f6400, -9), coef_q56(64'h17a1e50, -7),
                    -coef_q56(64'h1db2aee, -3), coef_q56(64'h1c5bf88, -1)};
   end

   // (x*y) >> sh, rounded half away from zero, magnitude capped at 2^63-1
   function automatic longint round_mul(longint x, longint y, int sh);
      logic         neg;
      logic [63:0]  ux, uy;
      logic [127:0] prod;
      logic [63:0]  mag;
      neg  = (x < 0) != (y < 0);
      ux   = x < 0 ? -x : x;
      uy   = y < 0 ? -y : y;
      prod = {64'd0, ux} * {64'd0, uy};
      prod = prod + (128'd1 << (sh - 1));
      if ((prod >> sh) > 128'h7FFFFFFFFFFFFFFF)
         mag = 64'h7FFFFFFFFFFFFFFF;
      else
         mag = prod >> sh;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clip_horner(longint v);
      if (v > HORNER_LIM) return HORNER_LIM;
      if (v < -HORNER_LIM) return -HORNER_LIM;
      return v;
   endfunction

   // natural log of u / 2^62 in Q.32, log2 by repeated squaring
   function automatic longint ln_of_one_minus(logic [63:0] u);
      int          lead;
      logic [63:0] m;
      logic [31:0] frac;
      lead = 62;
      frac = '0;
      while (lead > 31 && u[lead] == 1'b0) lead--;
      m = u >> (lead - 30);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return round_mul(longint'(lead - 62) * 64'sd4294967296 + longint'({32'd0, frac}),
                       LN2_FIXED, 62);
   endfunction

   function automatic logic signed [31:0] predict_erfinv(logic signed [31:0] arg);
      longint      a, t, p, r;
      logic [63:0] mag, u;
      a = arg;
      if (a == -64'sd2147483648) a = -64'sd2147483647;
      mag = a < 0 ? -a : a;
      u = (64'd1 << 62) - mag * mag;
      t = ln_of_one_minus(u);
      if (-t > TAIL_SPLIT) begin
         p = tail_coef[0];
         for (int i = 1; i < 9; i++)
            p = clip_horner(clip_horner(round_mul(p, t, 32)) + tail_coef[i]);
      end else begin
         p = core_coef[0];
         for (int i = 1; i < 10; i++)
            p = clip_horner(clip_horner(round_mul(p, t, 32)) + core_coef[i]);
      end
      r = round_mul(a, p, 59);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // directed table: argument, and a typed expectation where it is obvious
   typedef struct {
      logic signed [31:0] arg;
      logic               has_expect;
      logic signed [31:0] expect_value;
   } arg_row_type;

   arg_row_type directed_rows[] = '{
      '{32'sh00000000, 1'b1, 32'sh00000000},   // zero in, zero out
      '{32'sh00000001, 1'b0, '0},
      '{-32'sh00000001, 1'b0, '0},
      '{32'sh7FFFFFFF, 1'b0, '0},               // largest argument, deep tail
      '{32'sh80000001, 1'b0, '0},
      '{32'sh80000000, 1'b0, '0},               // -1 treated as -(1 - 2^-31)
      '{32'sh40000000, 1'b0, '0},
      '{32'shC0000000, 1'b0, '0},
      '{32'sh7FFF0000, 1'b0, '0},
      '{32'sh7FC00000, 1'b0, '0},               // near branch threshold
      '{32'sh7FC80000, 1'b0, '0},
      '{32'sh7FD00000, 1'b0, '0},
      '{32'sh7FD80000, 1'b0, '0},
      '{32'sh7FB00000, 1'b0, '0},
      '{32'sh55555555, 1'b0, '0},
      '{32'shAAAAAAAA, 1'b0, '0},
      '{32'sh7FFFFFFE, 1'b0, '0},
      '{32'sh0000FFFF, 1'b0, '0}
   };

   // argument for the random part
   logic signed [31:0] next_arg;

   // push one argument through the input channel
   task automatic send_arg(logic signed [31:0] arg, logic typed,
                           logic signed [31:0] typed_value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_arg_value <= arg;
      erfinv_queue.push_back(typed ? typed_value : predict_erfinv(arg));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      args_sent++;
   endtask

   function automatic logic signed [31:0] random_arg();
      logic signed [31:0] v;
      case ($urandom_range(4))
         0: v = $urandom;                                     // full range
         1: v = 32'sh7FC00000 + $urandom_range(32'h003FFFFF); // around threshold
         2: v = 32'sh7FFFFFFF - $urandom_range(32'h0000FFFF); // deep tail
         3: v = $urandom_range(32'h0000FFFF);                 // tiny arguments
         default: v = $urandom & 32'h7FFFFFFF;
      endcase
      if ($urandom_range(1)) v = -v;
      return v;
   endfunction

   task automatic drain_results();
      while (erfinv_queue.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_arg(directed_rows[i].arg, directed_rows[i].has_expect,
                  directed_rows[i].expect_value);

      // hold the sender until the pipeline has emptied
      req_valid <= 1'b0;
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 26 : phase == 1 ? 50 : 0;
         recv_idle_pct = phase == 0 ? 50 : phase == 1 ? 26 : 0;
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
            next_arg = random_arg();
            send_arg(next_arg, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d arguments, checked %0d results across three idling phases.",
               args_sent, results_seen);
      $display("Covered zero, extremes, -1, threshold region, tail and core branches.");
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // receiver: random stall, compare each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (erfinv_queue.size() == 0) begin
            $error("unexpected result inv_erf_value=%0d", rsp_inv_erf_value);
            failures++;
         end else begin
            if (rsp_inv_erf_value !== erfinv_queue[0]) begin
               $error("inv_erf_value: expected %0d actual %0d",
                      erfinv_queue[0], rsp_inv_erf_value);
               failures++;
            end
            void'(erfinv_queue.pop_front());
            results_seen++;
         end
      end
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

/* sim.f */
design/ierf_pkg.sv
design/ierf_front.sv
design/ierf_queue.sv
design/ierf_back.sv
design/inverse_error_function.sv
bench/testbench.sv
